>>> rtl/tds_pkg.sv
`default_nettype none

package tds_pkg;

    // field widths fixed by the item format
    localparam int NOW_W  = 48;
    localparam int KEY_W  = 64;
    localparam int LIFE_W = 32;

    // defaults for the top level parameters
    localparam int ENTRIES_DEF  = 32;
    localparam int KEY_BITS_DEF = 64;

    // lifetime after reset, in milliseconds
    localparam logic [LIFE_W-1:0] LIFE_RESET = LIFE_W'(600000);

    typedef struct packed {
        logic [NOW_W-1:0] now_ms;
        logic [KEY_W-1:0] key;
    } item_t;

    typedef struct packed {
        logic accepted;
        logic store_full;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXPIRE = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_SPARE  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

>>> rtl/tds_store.sv
`default_nettype none

module tds_store #(
    parameter int ENTRIES  = tds_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = tds_pkg::KEY_BITS_DEF,
    parameter int IDX_W    = $clog2(ENTRIES)
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [IDX_W-1:0]         wr_addr,
    input  wire logic [tds_pkg::NOW_W-1:0] wr_stamp,
    input  wire logic [KEY_BITS-1:0]      wr_key,
    input  wire logic [IDX_W-1:0]         rd_addr,
    output logic      [tds_pkg::NOW_W-1:0] rd_stamp,
    output logic      [KEY_BITS-1:0]      rd_key
);

    logic [tds_pkg::NOW_W-1:0] stamp_mem [ENTRIES];
    logic [KEY_BITS-1:0]       key_mem   [ENTRIES];

    // single write port, registered single read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stamp_mem[wr_addr] <= wr_stamp;
            key_mem[wr_addr]   <= wr_key;
        end
        rd_stamp <= stamp_mem[rd_addr];
        rd_key   <= key_mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/timed_duplicate_suppressor_top.sv
`default_nettype none

// Time-window duplicate filter. Each transfer on the item channel carries a
// millisecond stamp and a key; the block keeps a ring of up to ENTRIES distinct
// recent keys with their stamps. It first retires head entries whose stamp plus
// lifetime_ms is below now_ms (stopping at the first live one), then searches
// the live entries for the key: a hit gives accepted=0, a miss appends the key
// and gives accepted=1, and a miss on a full ring gives store_full=1. Only the
// low KEY_BITS bits of the key take part. A new item is taken only in idle, so
// the block finishes retiring, searching and handing over the result of one item
// before it takes the next; handing over waits for result_ready while the previous
// result is still held. The walk is set by the single read port of the key/stamp
// store, which walks one entry a cycle.
// The user writes lifetime_ms through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce this.

module timed_duplicate_suppressor_top #(
    parameter int ENTRIES  = tds_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = tds_pkg::KEY_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    output logic                            item_ready,
    input  wire tds_pkg::item_t             item,
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output tds_pkg::result_t                result,
    input  wire logic                       cfg_we,
    input  wire logic [tds_pkg::LIFE_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int NOW_W = tds_pkg::NOW_W;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(ENTRIES);

    tds_pkg::state_t state_reg, state_next;

    logic [tds_pkg::LIFE_W-1:0] life_reg;
    logic [IDX_W-1:0]           head_reg, head_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           slot_reg, slot_next;
    logic [NOW_W-1:0]           now_reg, now_next;
    logic [KEY_BITS-1:0]        key_reg, key_next;
    logic                       acc_reg, acc_next;
    logic                       full_reg, full_next;
    logic                       out_valid_reg, out_valid_next;
    tds_pkg::result_t           out_reg, out_next;

    logic [IDX_W-1:0]    rd_addr;
    logic [NOW_W-1:0]    rd_stamp;
    logic [KEY_BITS-1:0] rd_key;
    logic                wr_en;
    logic                expired;
    logic                out_free;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
        next_slot = (s == LAST_SLOT) ? '0 : s + IDX_W'(1);
    endfunction

    tds_store #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS),
        .IDX_W    (IDX_W)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (slot_reg),
        .wr_stamp (now_reg),
        .wr_key   (key_reg),
        .rd_addr  (rd_addr),
        .rd_stamp (rd_stamp),
        .rd_key   (rd_key)
    );

    // head entry has expired when stamp + lifetime < now, without overflow
    assign expired = ({1'b0, rd_stamp} + {{(NOW_W + 1 - tds_pkg::LIFE_W){1'b0}}, life_reg})
                     < {1'b0, now_reg};

    assign out_free     = !out_valid_reg || result_ready;
    assign item_ready   = (state_reg == tds_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        now_next       = now_reg;
        key_next       = key_reg;
        acc_next       = acc_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        rd_addr        = head_reg;
        wr_en          = 1'b0;

        unique case (state_reg)
            tds_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    now_next   = item.now_ms;
                    key_next   = item.key[KEY_BITS-1:0];
                    state_next = tds_pkg::ST_EXPIRE;
                end
            end
            tds_pkg::ST_EXPIRE:
            begin
                if ((count_reg != '0) && expired)
                begin
                    // retire head, prefetch the following slot
                    head_next  = next_slot(head_reg);
                    count_next = count_reg - CNT_W'(1);
                    rd_addr    = next_slot(head_reg);
                end
                else
                begin
                    idx_next   = '0;
                    slot_next  = head_reg;
                    rd_addr    = head_reg;
                    state_next = tds_pkg::ST_SEARCH;
                end
            end
            tds_pkg::ST_SEARCH:
            begin
                rd_addr = next_slot(slot_reg);
                if (idx_reg == count_reg)
                begin
                    // miss: slot_reg now points at the tail
                    acc_next   = (count_reg != FULL_CNT);
                    full_next  = (count_reg == FULL_CNT);
                    state_next = tds_pkg::ST_FINISH;
                end
                else if (rd_key == key_reg)
                begin
                    acc_next   = 1'b0;
                    full_next  = 1'b0;
                    state_next = tds_pkg::ST_FINISH;
                end
                else
                begin
                    idx_next  = idx_reg + CNT_W'(1);
                    slot_next = next_slot(slot_reg);
                end
            end
            tds_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    wr_en               = acc_reg;
                    out_valid_next      = 1'b1;
                    out_next.accepted   = acc_reg;
                    out_next.store_full = full_reg;
                    if (acc_reg)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = tds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tds_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tds_pkg::ST_IDLE;
            life_reg      <= tds_pkg::LIFE_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                life_reg <= cfg_wdata;
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        slot_reg <= slot_next;
        now_reg  <= now_next;
        key_reg  <= key_next;
        acc_reg  <= acc_next;
        full_reg <= full_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire
